// File: design/graph_segment_union_find_assert.svh
// Assertion macros shared by the segmentation engine modules.
`ifndef GRAPH_SEGMENT_UNION_FIND_ASSERT_SVH
`define GRAPH_SEGMENT_UNION_FIND_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define GSUF_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define GSUF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define GSUF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/gsuf_pkg.sv
package gsuf_pkg;

    localparam int unsigned VERTICES_DEF = 4096;
    localparam logic [16:0] LIMIT_MAX = 17'd131071;
    localparam logic [3:0] RANK_MAX = 4'd15;
    localparam logic [15:0] MC_RESET = 16'd256;
    localparam logic [12:0] MINC_RESET = 13'd0;

    typedef enum logic [1:0] {
        ACT_SEGMENT = 2'd0,
        ACT_SMALL   = 2'd1,
        ACT_QUERY   = 2'd2,
        ACT_RESTART = 2'd3
    } action_t;

    localparam logic REG_MERGE_CONST = 1'b0;
    localparam logic REG_MIN_COMP = 1'b1;

    typedef enum logic [4:0] {
        ST_CLR_BOOT,
        ST_IDLE,
        ST_MOD_A,
        ST_MOD_B,
        ST_DISP,
        ST_F_INIT,
        ST_F_RD,
        ST_F_CHK,
        ST_F_WB,
        ST_RA,
        ST_RB,
        ST_DEC,
        ST_UNITE,
        ST_LIM_S,
        ST_LIM_W,
        ST_WIN,
        ST_CLR_ITEM,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_MOD_A,
        OP_MOD_B,
        OP_RESTART,
        OP_FIND_INIT,
        OP_FIND_RD,
        OP_FIND_CHK,
        OP_FIND_WB,
        OP_RD_A,
        OP_RD_B,
        OP_DEC,
        OP_UNITE,
        OP_LIM_START,
        OP_WIN_WR,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_ROOT
    } phase_t;

    typedef struct packed {
        op_t    op;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic    clr_last;
        logic    walk_end;
        logic    div_done;
        logic    do_merge;
        logic    out_free;
        action_t act;
    } sts_t;

endpackage

// File: design/graph_segment_union_find.sv
// Channel   Handshake                 Payload
// input     in_valid / in_stall       action, vertex_a, vertex_b, weight
// output    out_valid / out_stall     root, merged, comp_size, set_count
// config    cfg_we                    cfg_index, cfg_data
//
// After reset the vertex table is swept clear, one entry a cycle.
// A restart request sweeps the table again.
// A query walks one parent chain; an edge walks three parent chains, and a merge adds
// a union write and a winner write, and a segment merge also waits on the divider.
// When VERTICES is below 4096 and not a power of two, each request first passes ST_MOD_A and ST_MOD_B.
// A result waits in the output register under out_stall while the next request is taken.
module graph_segment_union_find import gsuf_pkg::*; #(
    parameter int unsigned VERTICES = VERTICES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [11:0] vertex_a,
    input  logic [11:0] vertex_b,
    input  logic [15:0] weight,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] root,
    output logic        merged,
    output logic [12:0] comp_size,
    output logic [12:0] set_count
);

    cmd_t cmd;
    sts_t sts;

    gsuf_ctrl #(
        .VERTICES (VERTICES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    gsuf_dp #(
        .VERTICES (VERTICES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .action    (action),
        .vertex_a  (vertex_a),
        .vertex_b  (vertex_b),
        .weight    (weight),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .root      (root),
        .merged    (merged),
        .comp_size (comp_size),
        .set_count (set_count)
    );

endmodule

// File: design/gsuf_ram.sv
module gsuf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/gsuf_div.sv
module gsuf_div #(
    parameter int unsigned NW = 16,
    parameter int unsigned DW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int unsigned CNTW = $clog2(NW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [NW-1:0]   q_reg;
    logic [DW-1:0]   r_reg;
    logic [DW-1:0]   d_reg;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;

    assign trial = {r_reg, q_reg[NW-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[NW-2:0], ge};
            r_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// File: design/gsuf_ctrl.sv
`include "graph_segment_union_find_assert.svh"

module gsuf_ctrl import gsuf_pkg::*; #(
    parameter int unsigned VERTICES = VERTICES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam bit IDX_MOD = (VERTICES < 4096) && ((VERTICES & (VERTICES - 1)) != 0);

    state_t state_reg;
    state_t state_next;
    phase_t phase_reg;
    phase_t phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR_BOOT;
            phase_reg <= PH_A;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_CLR_BOOT:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = IDX_MOD ? ST_MOD_A : ST_DISP;
                end
            end
            ST_MOD_A: state_next = ST_MOD_B;
            ST_MOD_B: state_next = ST_DISP;
            ST_DISP:
            begin
                phase_next = PH_A;
                state_next = (sts.act == ACT_RESTART) ? ST_CLR_ITEM : ST_F_INIT;
            end
            ST_F_INIT: state_next = ST_F_RD;
            ST_F_RD:   state_next = ST_F_CHK;
            ST_F_CHK:  state_next = sts.walk_end ? ST_F_WB : ST_F_RD;
            ST_F_WB:
            begin
                case (phase_reg)
                    PH_A:
                    begin
                        if (sts.act == ACT_QUERY)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            phase_next = PH_B;
                            state_next = ST_F_INIT;
                        end
                    end
                    PH_B:    state_next = ST_RA;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_RA: state_next = ST_RB;
            ST_RB: state_next = ST_DEC;
            ST_DEC:
            begin
                if (sts.do_merge)
                begin
                    state_next = ST_UNITE;
                end
                else
                begin
                    phase_next = PH_ROOT;
                    state_next = ST_F_INIT;
                end
            end
            ST_UNITE: state_next = (sts.act == ACT_SEGMENT) ? ST_LIM_S : ST_WIN;
            ST_LIM_S: state_next = ST_LIM_W;
            ST_LIM_W:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_WIN;
                end
            end
            ST_WIN:
            begin
                phase_next = PH_ROOT;
                state_next = ST_F_INIT;
            end
            ST_CLR_ITEM:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op    = OP_NONE;
        cmd.phase = phase_reg;
        in_stall  = 1'b1;
        case (state_reg)
            ST_CLR_BOOT: cmd.op = OP_CLEAR;
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.op   = in_valid ? OP_LOAD : OP_NONE;
            end
            ST_MOD_A:  cmd.op = OP_MOD_A;
            ST_MOD_B:  cmd.op = OP_MOD_B;
            ST_DISP:   cmd.op = (sts.act == ACT_RESTART) ? OP_RESTART : OP_NONE;
            ST_F_INIT: cmd.op = OP_FIND_INIT;
            ST_F_RD:   cmd.op = OP_FIND_RD;
            ST_F_CHK:  cmd.op = OP_FIND_CHK;
            ST_F_WB:   cmd.op = OP_FIND_WB;
            ST_RA:     cmd.op = OP_RD_A;
            ST_RB:     cmd.op = OP_RD_B;
            ST_DEC:    cmd.op = OP_DEC;
            ST_UNITE:  cmd.op = OP_UNITE;
            ST_LIM_S:  cmd.op = OP_LIM_START;
            ST_LIM_W:  cmd.op = OP_NONE;
            ST_WIN:    cmd.op = OP_WIN_WR;
            ST_CLR_ITEM: cmd.op = OP_CLEAR;
            ST_DONE:   cmd.op = sts.out_free ? OP_OUT : OP_NONE;
            default:   cmd.op = OP_NONE;
        endcase
    end

    `GSUF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, state_reg != ST_IDLE, "request accepted but controller stayed idle")

endmodule

// File: design/gsuf_dp.sv
`include "graph_segment_union_find_assert.svh"

module gsuf_dp import gsuf_pkg::*; #(
    parameter int unsigned VERTICES = VERTICES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [1:0]  action,
    input  logic [11:0] vertex_a,
    input  logic [11:0] vertex_b,
    input  logic [15:0] weight,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] root,
    output logic        merged,
    output logic [12:0] comp_size,
    output logic [12:0] set_count
);

    localparam int unsigned AW = $clog2(VERTICES);
    localparam int unsigned SW = $clog2(VERTICES + 1);
    localparam int unsigned CW = (SW > 13) ? SW : 13;
    localparam int unsigned IW = (AW > 12) ? AW : 12;
    localparam int unsigned SZ_LO = 17;
    localparam int unsigned RK_LO = SZ_LO + SW;
    localparam int unsigned PAR_LO = RK_LO + 4;
    localparam int unsigned TCH = PAR_LO + AW;
    localparam int unsigned RW = TCH + 1;
    localparam int unsigned MOD_SH = 24;
    localparam logic [24:0] MOD_M =
        25'(((64'd1 << MOD_SH) + 64'(VERTICES) - 64'd1) / 64'(VERTICES));

    function automatic logic [RW-1:0] mk_row(input logic [AW-1:0] par, input logic [3:0] rk,
                                             input logic [SW-1:0] sz, input logic [16:0] lim);
        mk_row = {1'b1, par, rk, sz, lim};
    endfunction

    // The quotient comes from a scaled reciprocal, exact for every 12-bit index.
    function automatic logic [AW-1:0] idx_mod(input logic [11:0] v);
        logic [36:0] prod;
        logic [11:0] q;
        logic [31:0] qv;
        logic [11:0] r;
        prod = 37'(v) * 37'(MOD_M);
        q = prod[35:24];
        qv = 32'(q) * 32'(VERTICES);
        r = v - qv[11:0];
        idx_mod = AW'(r);
    endfunction

    logic [15:0]   mc_reg;
    logic [12:0]   minc_reg;
    logic [SW-1:0] comps_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          out_valid_reg;

    logic [11:0]   raw_a_reg;
    logic [11:0]   raw_b_reg;
    action_t       act_reg;
    logic [15:0]   w_reg;
    logic [AW-1:0] va_reg;
    logic [AW-1:0] vb_reg;
    logic [AW-1:0] x_reg;
    logic [AW-1:0] y_reg;
    logic [AW-1:0] p0_reg;
    logic          first_reg;
    logic [3:0]    xrk_reg;
    logic [SW-1:0] xsz_reg;
    logic [16:0]   xlim_reg;
    logic [AW-1:0] a_reg;
    logic [AW-1:0] b_reg;
    logic [3:0]    ark_reg;
    logic [SW-1:0] asz_reg;
    logic [16:0]   alim_reg;
    logic [3:0]    brk_reg;
    logic [SW-1:0] bsz_reg;
    logic [16:0]   blim_reg;
    logic [AW-1:0] win_reg;
    logic [3:0]    wrk_reg;
    logic [SW-1:0] wsz_reg;
    logic [16:0]   wlim_reg;
    logic [AW-1:0] res_root_reg;
    logic [SW-1:0] rsize_reg;
    logic          merged_reg;
    logic [11:0]   out_root_reg;
    logic          out_merged_reg;
    logic [12:0]   out_size_reg;
    logic [12:0]   out_count_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] rd;

    logic          div_start;
    logic          div_busy;
    logic          div_done;
    logic [15:0]   div_num;
    logic [SW-1:0] div_den;
    logic [15:0]   div_quo;

    logic [IW-1:0] va_ext;
    logic [IW-1:0] vb_ext;
    logic [AW-1:0] self_idx;
    logic [AW-1:0] e_par;
    logic [3:0]    e_rank;
    logic [SW-1:0] e_size;
    logic [16:0]   e_lim;
    logic          a_wins;
    logic [3:0]    win_rank;
    logic [SW-1:0] new_size;
    logic [17:0]   lim_sum;
    logic [16:0]   lim_new;
    logic          seg_ok;
    logic          small_ok;
    logic          clr_last;

    gsuf_ram #(
        .WIDTH (RW),
        .DEPTH (VERTICES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd)
    );

    gsuf_div #(
        .NW (16),
        .DW (SW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign va_ext = IW'(vertex_a);
    assign vb_ext = IW'(vertex_b);

    always_comb
    begin
        case (cmd.op)
            OP_RD_B: self_idx = a_reg;
            OP_DEC:  self_idx = b_reg;
            default: self_idx = y_reg;
        endcase
    end

    assign e_par  = rd[TCH] ? rd[PAR_LO +: AW] : self_idx;
    assign e_rank = rd[TCH] ? rd[RK_LO +: 4] : 4'd0;
    assign e_size = rd[TCH] ? rd[SZ_LO +: SW] : SW'(1);
    assign e_lim  = rd[TCH] ? rd[16:0] : {1'b0, mc_reg};

    assign a_wins   = ark_reg > brk_reg;
    assign win_rank = a_wins ? ark_reg
                    : (((ark_reg == brk_reg) && (brk_reg < RANK_MAX)) ? brk_reg + 4'd1 : brk_reg);
    assign new_size = asz_reg + bsz_reg;
    assign lim_sum  = {2'b00, w_reg} + {2'b00, div_quo};
    assign lim_new  = (act_reg != ACT_SEGMENT) ? wlim_reg
                    : ((lim_sum > {1'b0, LIMIT_MAX}) ? LIMIT_MAX : lim_sum[16:0]);

    assign seg_ok   = ({1'b0, w_reg} <= alim_reg) && ({1'b0, w_reg} <= e_lim);
    assign small_ok = (CW'(asz_reg) < CW'(minc_reg)) || (CW'(e_size) < CW'(minc_reg));
    assign clr_last = clr_cnt_reg == AW'(VERTICES - 1);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = x_reg;
        ram_wdata = mk_row(y_reg, xrk_reg, xsz_reg, xlim_reg);
        case (cmd.op)
            OP_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            OP_FIND_WB:
            begin
                ram_we = p0_reg != y_reg;
            end
            OP_UNITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = a_wins ? b_reg : a_reg;
                ram_wdata = a_wins ? mk_row(a_reg, brk_reg, bsz_reg, blim_reg)
                                   : mk_row(b_reg, ark_reg, asz_reg, alim_reg);
            end
            OP_WIN_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = win_reg;
                ram_wdata = mk_row(win_reg, wrk_reg, wsz_reg, lim_new);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            OP_RD_A: ram_raddr = a_reg;
            OP_RD_B: ram_raddr = b_reg;
            default: ram_raddr = y_reg;
        endcase
    end

    assign div_start = cmd.op == OP_LIM_START;
    assign div_num   = mc_reg;
    assign div_den   = wsz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mc_reg        <= MC_RESET;
            minc_reg      <= MINC_RESET;
            comps_reg     <= SW'(VERTICES);
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MERGE_CONST: mc_reg <= cfg_data;
                    REG_MIN_COMP:    minc_reg <= cfg_data[12:0];
                    default:         mc_reg <= mc_reg;
                endcase
            end
            if (cmd.op == OP_CLEAR)
            begin
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + AW'(1);
            end
            if (cmd.op == OP_RESTART)
            begin
                comps_reg <= SW'(VERTICES);
            end
            else if ((cmd.op == OP_UNITE) && (comps_reg > SW'(1)))
            begin
                comps_reg <= comps_reg - SW'(1);
            end
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                raw_a_reg  <= vertex_a;
                raw_b_reg  <= vertex_b;
                act_reg    <= action_t'(action);
                w_reg      <= weight;
                va_reg     <= va_ext[AW-1:0];
                vb_reg     <= vb_ext[AW-1:0];
                merged_reg <= 1'b0;
            end
            OP_MOD_A: va_reg <= idx_mod(raw_a_reg);
            OP_MOD_B: vb_reg <= idx_mod(raw_b_reg);
            OP_RESTART:
            begin
                res_root_reg <= va_reg;
                rsize_reg    <= SW'(1);
                merged_reg   <= 1'b0;
            end
            OP_FIND_INIT:
            begin
                x_reg     <= (cmd.phase == PH_B) ? vb_reg : va_reg;
                y_reg     <= (cmd.phase == PH_B) ? vb_reg : va_reg;
                first_reg <= 1'b1;
            end
            OP_FIND_CHK:
            begin
                if (first_reg)
                begin
                    p0_reg   <= e_par;
                    xrk_reg  <= e_rank;
                    xsz_reg  <= e_size;
                    xlim_reg <= e_lim;
                end
                first_reg <= 1'b0;
                if (e_par == y_reg)
                begin
                    rsize_reg <= e_size;
                end
                else
                begin
                    y_reg <= e_par;
                end
            end
            OP_FIND_WB:
            begin
                res_root_reg <= y_reg;
                if (cmd.phase == PH_A)
                begin
                    a_reg <= y_reg;
                end
                if (cmd.phase == PH_B)
                begin
                    b_reg <= y_reg;
                end
            end
            OP_RD_B:
            begin
                ark_reg  <= e_rank;
                asz_reg  <= e_size;
                alim_reg <= e_lim;
            end
            OP_DEC:
            begin
                brk_reg  <= e_rank;
                bsz_reg  <= e_size;
                blim_reg <= e_lim;
            end
            OP_UNITE:
            begin
                win_reg    <= a_wins ? a_reg : b_reg;
                wrk_reg    <= win_rank;
                wsz_reg    <= new_size;
                wlim_reg   <= a_wins ? alim_reg : blim_reg;
                merged_reg <= 1'b1;
            end
            OP_OUT:
            begin
                out_root_reg   <= 12'(res_root_reg);
                out_merged_reg <= merged_reg;
                out_size_reg   <= 13'(rsize_reg);
                out_count_reg  <= 13'(comps_reg);
            end
            default:
            begin
                first_reg <= first_reg;
            end
        endcase
    end

    assign sts.clr_last = clr_last;
    assign sts.walk_end = e_par == y_reg;
    assign sts.div_done = div_done;
    assign sts.do_merge = (a_reg != b_reg) && ((act_reg == ACT_SEGMENT) ? seg_ok : small_ok);
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign sts.act      = act_reg;

    assign out_valid = out_valid_reg;
    assign root      = out_root_reg;
    assign merged    = out_merged_reg;
    assign comp_size = out_size_reg;
    assign set_count = out_count_reg;

    `GSUF_ASSERT_HOLDS(a_count_nonzero, comps_reg != '0, "component count reached zero")
    `GSUF_ASSERT_IMPL(a_div_idle_start, div_start, !div_busy, "divider started while busy")
    `GSUF_ASSERT_IMPL(a_unite_distinct, cmd.op == OP_UNITE, a_reg != b_reg, "union of one root with itself")

endmodule

// File: dv/graph_segment_union_find_tb.sv
module graph_segment_union_find_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gsuf_pkg::*;

    localparam int unsigned NV = 4096;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [11:0] root;
        logic        merged;
        logic [12:0] comp_size;
        logic [12:0] set_count;
    } label_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [11:0] vertex_a;
    logic [11:0] vertex_b;
    logic [15:0] weight;
    logic        out_valid;
    logic        out_stall;
    logic [11:0] root;
    logic        merged;
    logic [12:0] comp_size;
    logic [12:0] set_count;

    // Shadow of the vertex table and the two registers.
    logic [11:0] up_link [NV];
    logic [3:0]  height [NV];
    logic [12:0] members [NV];
    logic [16:0] limit_of [NV];
    logic        live [NV];
    logic [12:0] forest_sets;
    logic [15:0] c_shadow;
    logic [12:0] minc_shadow;

    label_t      labels_due[$];
    int          errors;
    int unsigned cycles;

    graph_segment_union_find dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [11:0] link_of(input logic [11:0] v);
        return live[v] ? up_link[v] : v;
    endfunction

    function automatic logic [12:0] size_of(input logic [11:0] v);
        return live[v] ? members[v] : 13'd1;
    endfunction

    function automatic logic [16:0] lim_of(input logic [11:0] v);
        return live[v] ? limit_of[v] : {1'b0, c_shadow};
    endfunction

    task automatic wake(input logic [11:0] v);
        if (!live[v])
        begin
            up_link[v] = v;
            height[v] = 4'd0;
            members[v] = 13'd1;
            limit_of[v] = {1'b0, c_shadow};
            live[v] = 1'b1;
        end
    endtask

    task automatic seek_root(input logic [11:0] x, output logic [11:0] top);
        logic [11:0] y;
        int steps;
        y = x;
        steps = 0;
        while (steps < NV && link_of(y) != y)
        begin
            y = link_of(y);
            steps++;
        end
        if (link_of(x) != y)
        begin
            wake(x);
            up_link[x] = y;
        end
        top = y;
    endtask

    task automatic join_roots(input logic [11:0] x, input logic [11:0] y);
        logic [3:0] hx;
        logic [3:0] hy;
        hx = live[x] ? height[x] : 4'd0;
        hy = live[y] ? height[y] : 4'd0;
        wake(x);
        wake(y);
        if (hx > hy)
        begin
            up_link[y] = x;
            members[x] = members[x] + members[y];
        end
        else
        begin
            up_link[x] = y;
            members[y] = members[y] + members[x];
            if (hx == hy && hy < RANK_MAX)
                height[y] = hy + 4'd1;
        end
        if (forest_sets > 1)
            forest_sets = forest_sets - 1;
    endtask

    task automatic clear_forest();
        foreach (live[i])
            live[i] = 1'b0;
        forest_sets = 13'(NV);
    endtask

    task automatic predict_label(input action_t act, input logic [11:0] va,
                                 input logic [11:0] vb, input logic [15:0] w);
        label_t      lab;
        logic [11:0] a;
        logic [11:0] b;
        logic [11:0] r;
        logic [12:0] s;
        logic [31:0] lim;
        lab.merged = 1'b0;
        if (act == ACT_RESTART)
        begin
            clear_forest();
            lab.root = va;
        end
        else
        begin
            if (act == ACT_SEGMENT)
            begin
                seek_root(va, a);
                seek_root(vb, b);
                if (a != b && {1'b0, w} <= lim_of(a) && {1'b0, w} <= lim_of(b))
                begin
                    join_roots(a, b);
                    seek_root(a, r);
                    s = size_of(r);
                    lim = 32'(w) + 32'(c_shadow) / (s != 0 ? 32'(s) : 32'd1);
                    if (lim > 32'(LIMIT_MAX))
                        lim = 32'(LIMIT_MAX);
                    wake(r);
                    limit_of[r] = lim[16:0];
                    lab.merged = 1'b1;
                end
            end
            else if (act == ACT_SMALL)
            begin
                seek_root(va, a);
                seek_root(vb, b);
                if (a != b && (size_of(a) < minc_shadow || size_of(b) < minc_shadow))
                begin
                    join_roots(a, b);
                    lab.merged = 1'b1;
                end
            end
            seek_root(va, lab.root);
        end
        lab.comp_size = size_of(lab.root);
        lab.set_count = forest_sets;
        labels_due.push_back(lab);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    int stall_mode;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (stall_mode == 0)
                out_stall <= 1'b0;
            else if (stall_mode == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 9) != 0);
        end
    end

    always @(posedge clk)
    begin
        label_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (labels_due.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                want = labels_due.pop_front();
                if (root !== want.root)
                begin
                    $error("root expected %0d actual %0d", want.root, root);
                    errors++;
                end
                if (merged !== want.merged)
                begin
                    $error("merged expected %0d actual %0d", want.merged, merged);
                    errors++;
                end
                if (comp_size !== want.comp_size)
                begin
                    $error("comp_size expected %0d actual %0d", want.comp_size, comp_size);
                    errors++;
                end
                if (set_count !== want.set_count)
                begin
                    $error("set_count expected %0d actual %0d", want.set_count, set_count);
                    errors++;
                end
            end
        end
    end

    task automatic send_request(input action_t act, input logic [11:0] va,
                                input logic [11:0] vb, input logic [15:0] w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        vertex_a <= va;
        vertex_b <= vb;
        weight <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_label(act, va, vb, w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (labels_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MERGE_CONST)
            c_shadow = value;
        else
            minc_shadow = value[12:0];
    endtask

    task automatic test_directed();
        send_request(ACT_QUERY, 12'd0, 12'd0, 16'd0);
        send_request(ACT_QUERY, 12'hFFF, 12'hFFF, 16'hFFFF);
        send_request(ACT_SEGMENT, 12'd0, 12'hFFF, 16'd0);
        send_request(ACT_SEGMENT, 12'd0, 12'hFFF, 16'd0);
        send_request(ACT_SEGMENT, 12'd1, 12'd2, 16'hFFFF);
        send_request(ACT_SEGMENT, 12'd1, 12'd2, 16'd256);
        send_request(ACT_SEGMENT, 12'd2, 12'd0, 16'd60);
        send_request(ACT_SEGMENT, 12'd3, 12'd4, 16'd200);
        send_request(ACT_SMALL, 12'd5, 12'd6, 16'hAAAA);
        send_request(ACT_QUERY, 12'hFFF, 12'd5, 16'd0);
        send_request(ACT_RESTART, 12'hABC, 12'h555, 16'h5555);
        send_request(ACT_QUERY, 12'd1, 12'd0, 16'd0);
        drain();
        write_reg(REG_MERGE_CONST, 16'hFFFF);
        write_reg(REG_MIN_COMP, 16'd3);
        send_request(ACT_SEGMENT, 12'd7, 12'd8, 16'hFFFF);
        send_request(ACT_SEGMENT, 12'd9, 12'd8, 16'hFFFF);
        send_request(ACT_SMALL, 12'd10, 12'd11, 16'd0);
        send_request(ACT_SMALL, 12'd7, 12'd10, 16'd0);
        send_request(ACT_SMALL, 12'd7, 12'd10, 16'd0);
        send_request(ACT_QUERY, 12'd11, 12'd0, 16'd0);
        drain();
    endtask

    task automatic test_random_phase(input int count, input logic [11:0] span,
                                     input logic [15:0] c_value, input logic [12:0] minc);
        logic [15:0] w;
        int roll;
        action_t act;
        write_reg(REG_MERGE_CONST, c_value);
        write_reg(REG_MIN_COMP, {3'd0, minc});
        send_request(ACT_RESTART, 12'($urandom), 12'($urandom), 16'($urandom));
        w = 16'd0;
        stall_mode = $urandom_range(0, 2);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                stall_mode = $urandom_range(0, 2);
            roll = $urandom_range(0, 99);
            act = roll < 60 ? ACT_SEGMENT : roll < 80 ? ACT_SMALL : ACT_QUERY;
            w = w + 16'($urandom_range(0, 40));
            if ($urandom_range(0, 19) == 0)
                w = 16'($urandom);
            if (span == 12'hFFF && $urandom_range(0, 3) == 0)
                send_request(act, 12'($urandom), 12'($urandom), w);
            else
                send_request(act, 12'($urandom_range(0, span)),
                             12'($urandom_range(0, span)), w);
        end
        stall_mode = 0;
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 16'd0;
        in_valid = 1'b0;
        action = 2'd0;
        vertex_a = 12'd0;
        vertex_b = 12'd0;
        weight = 16'd0;
        errors = 0;
        cycles = 0;
        stall_mode = 0;
        c_shadow = MC_RESET;
        minc_shadow = MINC_RESET;
        clear_forest();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(210, 12'd31, 16'd1024, 13'd4);
        test_random_phase(210, 12'd15, 16'd0, 13'd0);
        test_random_phase(210, 12'd63, 16'd65535, 13'd4096);
        test_random_phase(210, 12'hFFF, 16'(300 + $urandom_range(0, 3000)),
                          13'($urandom_range(1, 8)));
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
